@@ design/spw_pkg.sv @@
// Shared types, codes and fragment field helpers for the sparse property header walker.
`timescale 1ns / 1ps

package spw_pkg;

  localparam int IDX_W   = 14;
  localparam int TOTAL_W = 14;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'h3fff;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_ADV   = 2'd2;

  localparam logic [2:0] ST_MORE  = 3'd0;
  localparam logic [2:0] ST_HDR   = 3'd1;
  localparam logic [2:0] ST_FOUND = 3'd2;
  localparam logic [2:0] ST_NONE  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  // Fragment word flag masks: bit 8 marks the last fragment, bit 7 marks a fragment with zero marks.
  localparam logic [15:0] FRAG_LAST_BIT = 16'h0100;
  localparam logic [15:0] FRAG_HZ_BIT   = 16'h0080;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FRAG_LO,
    PH_FRAG_HI,
    PH_MASK,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_FETCH,
    WS_SKIP,
    WS_MASK,
    WS_TEST
  } walk_state_t;

  typedef struct packed {
    logic done;
    logic error;
    logic all_empty;
  } parse_info_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       status;
    logic [IDX_W-1:0] index;
  } res_t;

  function automatic logic [6:0] frag_skip(input logic [15:0] w);
    return w[6:0];
  endfunction

  function automatic logic frag_hz(input logic [15:0] w);
    return (w & FRAG_HZ_BIT) != 16'h0000;
  endfunction

  function automatic logic frag_last(input logic [15:0] w);
    return (w & FRAG_LAST_BIT) != 16'h0000;
  endfunction

  function automatic logic [6:0] frag_values(input logic [15:0] w);
    return w[15:9];
  endfunction

endpackage

@@ design/sparse_property_header_walker_unit.sv @@
// Top level of the sparse property header walker: command dispatch, memories and result buffer.
`timescale 1ns / 1ps

// Sparse property header walker. Feed a start beat (command 0), then the header
// one byte per beat (command 1): 16-bit little-endian fragment words, then the
// zero-mask bytes if any fragment carries zero marks. Every accepted beat gives
// exactly one result beat (status, property_index). Once the header is complete,
// each advance beat (command 2) returns the next present non-zero property index
// or "no more". Fragments live in a MAX_FRAGMENTS x 16 RAM and the zero mask in a
// MAX_MASK_BITS/32 x 32 RAM, both with registered reads. An advance that walks
// fetches fragment words from the fragment RAM and tests entries against the mask
// RAM; the walker handles one beat at a time and in_stall stays high until it
// answers. A two-entry result buffer (output register plus skid) lets a new beat
// enter while a result is still waiting on out_stall. No clearing pass is needed
// after reset: mask words carry valid bits that reset and start clear at once.
module sparse_property_header_walker_unit #(
  parameter int MAX_FRAGMENTS = 64,
  parameter int MAX_MASK_BITS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  header_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [13:0] property_index
);

  localparam int FAW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int FCW = $clog2(MAX_FRAGMENTS + 1);
  localparam int MASK_WORDS = MAX_MASK_BITS / 32;
  localparam int MWA = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

  logic accept;
  logic start, byte_en, go;
  logic [2:0] byte_status;
  spw_pkg::parse_info_t info;
  logic [FCW-1:0] frag_count;

  // fragment RAM ports
  logic           frag_we;
  logic [FAW-1:0] frag_waddr;
  logic [15:0]    frag_wdata;
  logic           frag_rd_en;
  logic [FAW-1:0] frag_rd_addr;
  logic [15:0]    frag_rdata;

  // mask RAM ports
  logic                  mask_we;
  logic [MWA-1:0]        mask_waddr;
  logic [31:0]           mask_wdata;
  logic                  mask_rd_en;
  logic [MWA-1:0]        mask_rd_addr;
  logic [31:0]           mask_rdata;
  logic [MASK_WORDS-1:0] mask_valid;

  logic          walk_busy;
  spw_pkg::res_t walk_res, imm_res, res;

  // result buffer: output register and one skid entry
  logic          skid_valid;
  logic [2:0]    skid_status;
  logic [13:0]   skid_index;
  logic          take;
  logic          out_free;

  assign accept  = in_valid && !in_stall;
  assign start   = accept && (command == spw_pkg::CMD_START);
  assign byte_en = accept && (command == spw_pkg::CMD_BYTE);
  // advance only hands off to the walker once the header is complete
  assign go      = accept && (command == spw_pkg::CMD_ADV) && info.done;

  // the walker holds the input side while it runs; a full skid holds it too
  assign in_stall = walk_busy || skid_valid;

  always_comb begin
    imm_res.valid  = accept && !go;
    imm_res.index  = '0;
    imm_res.status = spw_pkg::ST_MORE;
    unique case (command)
      spw_pkg::CMD_BYTE: imm_res.status = byte_status;
      spw_pkg::CMD_ADV:  imm_res.status = info.error ? spw_pkg::ST_ERR : spw_pkg::ST_MORE;
      default:           imm_res.status = spw_pkg::ST_MORE;
    endcase
  end

  // walker answers only for its own beat, never in the same cycle as an immediate one
  assign res = walk_res.valid ? walk_res : imm_res;

  spw_parse #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS),
    .MAX_MASK_BITS(MAX_MASK_BITS)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .byte_en     (byte_en),
    .header_byte (header_byte),
    .byte_status (byte_status),
    .info        (info),
    .frag_count  (frag_count),
    .frag_we     (frag_we),
    .frag_waddr  (frag_waddr),
    .frag_wdata  (frag_wdata),
    .mask_we     (mask_we),
    .mask_waddr  (mask_waddr),
    .mask_wdata  (mask_wdata),
    .mask_valid  (mask_valid)
  );

  spw_walk #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS),
    .MAX_MASK_BITS(MAX_MASK_BITS)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .clear        (start),
    .go           (go),
    .info         (info),
    .frag_count   (frag_count),
    .frag_rd_en   (frag_rd_en),
    .frag_rd_addr (frag_rd_addr),
    .frag_rdata   (frag_rdata),
    .mask_rd_en   (mask_rd_en),
    .mask_rd_addr (mask_rd_addr),
    .mask_rdata   (mask_rdata),
    .mask_valid   (mask_valid),
    .busy         (walk_busy),
    .res          (walk_res)
  );

  spw_ram #(
    .WIDTH(16),
    .DEPTH(MAX_FRAGMENTS)
  ) u_frag_ram (
    .clk     (clk),
    .wr_en   (frag_we),
    .wr_addr (frag_waddr),
    .wr_data (frag_wdata),
    .rd_en   (frag_rd_en),
    .rd_addr (frag_rd_addr),
    .rd_data (frag_rdata)
  );

  spw_ram #(
    .WIDTH(32),
    .DEPTH(MASK_WORDS)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (mask_we),
    .wr_addr (mask_waddr),
    .wr_data (mask_wdata),
    .rd_en   (mask_rd_en),
    .rd_addr (mask_rd_addr),
    .rd_data (mask_rdata)
  );

  assign take     = out_valid && !out_stall;
  assign out_free = !out_valid || take;

  // Result buffer control. The skid drains first; a new result goes to the
  // output register when it frees up, otherwise it parks in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_free) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (res.valid) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        status         <= skid_status;
        property_index <= skid_index;
      end
    end else if (res.valid) begin
      if (out_free) begin
        status         <= res.status;
        property_index <= res.index;
      end else begin
        skid_status <= res.status;
        skid_index  <= res.index;
      end
    end
  end

endmodule

@@ design/spw_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module spw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/spw_parse.sv @@
// Header byte parser: fragment capture, value totals and zero-mask word assembly.
`timescale 1ns / 1ps

module spw_parse #(
  parameter int MAX_FRAGMENTS = 64,
  parameter int MAX_MASK_BITS = 256,
  localparam int FAW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1,
  localparam int FCW = $clog2(MAX_FRAGMENTS + 1),
  localparam int MASK_WORDS = MAX_MASK_BITS / 32,
  localparam int MWA = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1,
  localparam int MB = ((MAX_MASK_BITS + 31) / 32) * 4,
  localparam int BCW = $clog2(MB + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   byte_en,
  input  logic [7:0]             header_byte,
  output logic [2:0]             byte_status,
  output spw_pkg::parse_info_t   info,
  output logic [FCW-1:0]         frag_count,
  output logic                   frag_we,
  output logic [FAW-1:0]         frag_waddr,
  output logic [15:0]            frag_wdata,
  output logic                   mask_we,
  output logic [MWA-1:0]         mask_waddr,
  output logic [31:0]            mask_wdata,
  output logic [MASK_WORDS-1:0]  mask_valid
);

  spw_pkg::phase_t phase, phase_next;
  logic [FCW-1:0]  frag_count_next;
  logic [spw_pkg::TOTAL_W-1:0] masked_total, masked_total_next;
  logic [spw_pkg::TOTAL_W-1:0] unmasked_total, unmasked_total_next;
  logic [BCW-1:0]  byte_counter, byte_counter_next;
  logic [BCW-1:0]  mask_bytes, mask_bytes_next;
  logic [7:0]      low_byte;
  logic [31:0]     mask_asm;
  logic [MASK_WORDS-1:0] mask_valid_next;

  logic [15:0] word;
  logic [spw_pkg::TOTAL_W:0] m_sum, u_sum, m_round;
  logic [spw_pkg::TOTAL_W-1:0] m_add, u_add, m_new;
  logic [BCW-1:0] bc_inc;
  logic [BCW-3:0] mword;
  logic [1:0]     lane;

  assign word  = {header_byte, low_byte};
  assign m_sum = {1'b0, masked_total} + 15'(spw_pkg::frag_values(word));
  assign u_sum = {1'b0, unmasked_total} + 15'(spw_pkg::frag_values(word));
  assign m_add = (m_sum > 15'(spw_pkg::TOTAL_MAX)) ? spw_pkg::TOTAL_MAX : m_sum[13:0];
  assign u_add = (u_sum > 15'(spw_pkg::TOTAL_MAX)) ? spw_pkg::TOTAL_MAX : u_sum[13:0];
  assign m_new = spw_pkg::frag_hz(word) ? m_add : masked_total;
  assign m_round = ({1'b0, m_new} + 15'd31) >> 5;
  assign bc_inc = byte_counter + BCW'(1);
  assign mword  = byte_counter[BCW-1:2];
  assign lane   = byte_counter[1:0];

  assign frag_waddr = FAW'(frag_count);
  assign frag_wdata = word;
  assign mask_waddr = MWA'(mword);
  assign mask_wdata = ((lane == 2'd0) ? 32'h0 : mask_asm) | (32'(header_byte) << {lane, 3'b000});

  assign info.done      = (phase == spw_pkg::PH_DONE);
  assign info.error     = (phase == spw_pkg::PH_ERROR);
  assign info.all_empty = (masked_total == '0) && (unmasked_total == '0);

  always_comb begin
    phase_next          = phase;
    frag_count_next     = frag_count;
    masked_total_next   = masked_total;
    unmasked_total_next = unmasked_total;
    byte_counter_next   = byte_counter;
    mask_bytes_next     = mask_bytes;
    mask_valid_next     = mask_valid;
    byte_status         = spw_pkg::ST_MORE;
    frag_we             = 1'b0;
    mask_we             = 1'b0;
    if (start) begin
      phase_next          = spw_pkg::PH_FRAG_LO;
      frag_count_next     = '0;
      masked_total_next   = '0;
      unmasked_total_next = '0;
      byte_counter_next   = '0;
      mask_valid_next     = '0;
    end else if (byte_en) begin
      unique case (phase)
        spw_pkg::PH_FRAG_LO: begin
          phase_next = spw_pkg::PH_FRAG_HI;
        end
        spw_pkg::PH_FRAG_HI: begin
          if (frag_count >= FCW'(MAX_FRAGMENTS)) begin
            phase_next  = spw_pkg::PH_ERROR;
            byte_status = spw_pkg::ST_ERR;
          end else begin
            frag_we         = 1'b1;
            frag_count_next = frag_count + FCW'(1);
            if (spw_pkg::frag_hz(word)) begin
              masked_total_next = m_add;
            end else begin
              unmasked_total_next = u_add;
            end
            if (!spw_pkg::frag_last(word)) begin
              phase_next = spw_pkg::PH_FRAG_LO;
            end else if (m_new == '0) begin
              phase_next  = spw_pkg::PH_DONE;
              byte_status = spw_pkg::ST_HDR;
            end else if (m_new > 14'(MAX_MASK_BITS)) begin
              phase_next  = spw_pkg::PH_ERROR;
              byte_status = spw_pkg::ST_ERR;
            end else begin
              if (m_new <= 14'd8) begin
                mask_bytes_next = BCW'(1);
              end else if (m_new <= 14'd16) begin
                mask_bytes_next = BCW'(2);
              end else begin
                mask_bytes_next = BCW'({m_round, 2'b00});
              end
              byte_counter_next = '0;
              phase_next        = spw_pkg::PH_MASK;
            end
          end
        end
        spw_pkg::PH_MASK: begin
          if (32'(mword) < 32'(MASK_WORDS)) begin
            mask_we = 1'b1;
            mask_valid_next[MWA'(mword)] = 1'b1;
          end
          byte_counter_next = bc_inc;
          if (bc_inc >= mask_bytes) begin
            phase_next  = spw_pkg::PH_DONE;
            byte_status = spw_pkg::ST_HDR;
          end
        end
        spw_pkg::PH_DONE:  byte_status = spw_pkg::ST_HDR;
        spw_pkg::PH_ERROR: byte_status = spw_pkg::ST_ERR;
        default:           byte_status = spw_pkg::ST_MORE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= spw_pkg::PH_IDLE;
      frag_count     <= '0;
      masked_total   <= '0;
      unmasked_total <= '0;
      byte_counter   <= '0;
      mask_valid     <= '0;
    end else begin
      phase          <= phase_next;
      frag_count     <= frag_count_next;
      masked_total   <= masked_total_next;
      unmasked_total <= unmasked_total_next;
      byte_counter   <= byte_counter_next;
      mask_valid     <= mask_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mask_bytes <= mask_bytes_next;
    if (byte_en && phase == spw_pkg::PH_FRAG_LO) begin
      low_byte <= header_byte;
    end
    if (mask_we) begin
      mask_asm <= mask_wdata;
    end
  end

endmodule

@@ design/spw_walk.sv @@
// Walk sequencer: steps through stored fragments and zero-mask words to find present values.
`timescale 1ns / 1ps

module spw_walk #(
  parameter int MAX_FRAGMENTS = 64,
  parameter int MAX_MASK_BITS = 256,
  localparam int FAW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1,
  localparam int FCW = $clog2(MAX_FRAGMENTS + 1),
  localparam int MASK_WORDS = MAX_MASK_BITS / 32,
  localparam int MWA = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1,
  localparam int ZW = $clog2(MAX_MASK_BITS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  go,
  input  spw_pkg::parse_info_t  info,
  input  logic [FCW-1:0]        frag_count,
  output logic                  frag_rd_en,
  output logic [FAW-1:0]        frag_rd_addr,
  input  logic [15:0]           frag_rdata,
  output logic                  mask_rd_en,
  output logic [MWA-1:0]        mask_rd_addr,
  input  logic [31:0]           mask_rdata,
  input  logic [MASK_WORDS-1:0] mask_valid,
  output logic                  busy,
  output spw_pkg::res_t         res
);

  spw_pkg::walk_state_t state, state_next;
  logic [spw_pkg::IDX_W-1:0] index, index_next;
  logic [FAW-1:0] frag, frag_next;
  logic [6:0]     remaining, remaining_next;
  logic [ZW-1:0]  zmi, zmi_next;
  logic           started, started_next;
  logic           done, done_next;
  logic           skip_pending, skip_pending_next;
  logic [15:0]    cur, cur_next;
  logic           mbit_ok, mbit_ok_next;

  logic [ZW-1:0]  zword;
  logic           zword_in;
  logic           at_end_cur;
  logic           at_end_rd;
  logic           nz;

  assign zword      = zmi >> 5;
  assign zword_in   = 32'(zword) < 32'(MASK_WORDS);
  assign at_end_cur = (FCW'(frag) + FCW'(1)) >= frag_count;
  assign at_end_rd  = spw_pkg::frag_last(frag_rdata) || at_end_cur;
  assign nz         = !spw_pkg::frag_hz(cur) || !(mbit_ok && mask_rdata[zmi[4:0]]);

  assign frag_rd_addr = frag;
  assign mask_rd_addr = MWA'(zword);
  assign busy         = (state != spw_pkg::WS_IDLE);

  always_comb begin
    state_next        = state;
    index_next        = index;
    frag_next         = frag;
    remaining_next    = remaining;
    zmi_next          = zmi;
    started_next      = started;
    done_next         = done;
    skip_pending_next = skip_pending;
    cur_next          = cur;
    mbit_ok_next      = mbit_ok;
    frag_rd_en        = 1'b0;
    mask_rd_en        = 1'b0;
    res.valid         = 1'b0;
    res.status        = spw_pkg::ST_NONE;
    res.index         = '0;
    unique case (state)
      spw_pkg::WS_IDLE: begin
        if (go) begin
          if (!started) begin
            started_next = 1'b1;
            frag_next    = '0;
            index_next   = '0;
            zmi_next     = '0;
            if (info.all_empty) begin
              done_next = 1'b1;
              res.valid = 1'b1;
            end else begin
              state_next = spw_pkg::WS_FETCH;
            end
          end else if (done) begin
            res.valid = 1'b1;
          end else if (skip_pending) begin
            state_next = spw_pkg::WS_FETCH;
          end else begin
            state_next = spw_pkg::WS_MASK;
          end
        end
      end
      spw_pkg::WS_FETCH: begin
        frag_rd_en = 1'b1;
        state_next = spw_pkg::WS_SKIP;
      end
      spw_pkg::WS_SKIP: begin
        cur_next   = frag_rdata;
        index_next = index + spw_pkg::IDX_W'(spw_pkg::frag_skip(frag_rdata));
        if (spw_pkg::frag_values(frag_rdata) == 7'd0) begin
          if (at_end_rd) begin
            done_next         = 1'b1;
            skip_pending_next = 1'b0;
            res.valid         = 1'b1;
            state_next        = spw_pkg::WS_IDLE;
          end else begin
            frag_next  = frag + FAW'(1);
            state_next = spw_pkg::WS_FETCH;
          end
        end else begin
          remaining_next    = spw_pkg::frag_values(frag_rdata);
          skip_pending_next = 1'b0;
          state_next        = spw_pkg::WS_MASK;
        end
      end
      spw_pkg::WS_MASK: begin
        mask_rd_en   = 1'b1;
        mbit_ok_next = zword_in && mask_valid[MWA'(zword)];
        state_next   = spw_pkg::WS_TEST;
      end
      spw_pkg::WS_TEST: begin
        index_next     = index + spw_pkg::IDX_W'(1);
        remaining_next = remaining - 7'd1;
        if (spw_pkg::frag_hz(cur)) begin
          zmi_next = zmi + ZW'(1);
        end
        if (remaining == 7'd1) begin
          if (spw_pkg::frag_last(cur) || at_end_cur) begin
            done_next = 1'b1;
          end else begin
            frag_next         = frag + FAW'(1);
            skip_pending_next = 1'b1;
          end
        end
        if (nz) begin
          res.valid  = 1'b1;
          res.status = spw_pkg::ST_FOUND;
          res.index  = index;
          state_next = spw_pkg::WS_IDLE;
        end else if (done_next) begin
          res.valid  = 1'b1;
          state_next = spw_pkg::WS_IDLE;
        end else if (skip_pending_next) begin
          state_next = spw_pkg::WS_FETCH;
        end else begin
          state_next = spw_pkg::WS_MASK;
        end
      end
      default: begin
        state_next = spw_pkg::WS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state        <= spw_pkg::WS_IDLE;
      index        <= '0;
      frag         <= '0;
      remaining    <= '0;
      zmi          <= '0;
      started      <= 1'b0;
      done         <= 1'b0;
      skip_pending <= 1'b0;
    end else begin
      state        <= state_next;
      index        <= index_next;
      frag         <= frag_next;
      remaining    <= remaining_next;
      zmi          <= zmi_next;
      started      <= started_next;
      done         <= done_next;
      skip_pending <= skip_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    mbit_ok <= mbit_ok_next;
  end

endmodule
